// ===== rtl/bfs_pkg.sv =====
// Shared types and constants for the spectrum bar falloff smoother.
`timescale 1ns / 1ps

package bfs_pkg;

    // Number of bars the per-bar store can serve; bar_index is 8 bits wide.
    localparam int NUM_BARS  = 256;
    localparam int BAR_DEPTH = (NUM_BARS < 256) ? NUM_BARS : 256;
    localparam int BAR_AW    = (BAR_DEPTH > 1) ? $clog2(BAR_DEPTH) : 1;

    // APB address width: four 32-bit registers at 4-byte spacing
    localparam int APB_AW = 4;

    // Register reset values
    localparam logic [31:0] FALLOFF_COEF_RST  = 32'd8895;
    localparam logic [15:0] INTEGRAL_COEF_RST = 16'd25830;
    localparam logic [15:0] FULL_SCALE_RST    = 16'd65534;
    localparam logic [31:0] SENSE_RST         = 32'd6553600;

    // Reciprocals for division by a constant (multiply, then shift right)
    localparam logic [31:0] RECIP_5_Q32   = 32'd858993460;   // 1/5,   >> 32
    localparam logic [31:0] RECIP_25_Q36  = 32'd2748779070;  // 1/25,  >> 36
    localparam logic [31:0] RECIP_125_Q36 = 32'd549755814;   // 1/125, >> 36
    localparam logic [31:0] RECIP_5_Q34   = 32'd3435973837;  // 1/5,   >> 34

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_FALLOFF_COEF  = 2'd0,
        REG_INTEGRAL_COEF = 2'd1,
        REG_FULL_SCALE    = 2'd2,
        REG_AUTOSENSE     = 2'd3
    } bfs_reg_t;

    // One input request
    typedef struct packed {
        logic [7:0]  bar_index;
        logic [30:0] raw_level;
        logic        frame_end;
    } bfs_item_t;

    // One result request
    typedef struct packed {
        logic [30:0] brightness;
        logic [31:0] sensitivity;
        logic        frame_done;
    } bfs_result_t;

    // Per-bar state entry
    typedef struct packed {
        logic [30:0] last_level;
        logic [30:0] peak_level;
        logic [15:0] fall_count;
        logic [30:0] integral_mem;
    } bfs_bar_t;

    localparam int BAR_W = $bits(bfs_bar_t);

endpackage

// ===== rtl/bar_falloff_smoother.sv =====
// Top level of the spectrum bar falloff smoother: sequencer, shared multiplier, registers.
`timescale 1ns / 1ps

// Takes one raw bar level per request and returns one smoothed brightness with the
// current sensitivity. Each request runs through a small sequencer around a single
// 32x32 multiplier with a registered product, so one request holds the input side from
// acceptance until it returns to idle. A bar with falloff and smoothing both off runs
// load, sense and write-back; a falling bar adds fall squared, times coefficient, apply;
// smoothing adds memory product, add, divide by 20, apply; a sensitivity drop adds its
// apply; the frame-end raise adds a product and an add, and the startup boost another
// product and add. Every step that needs a product reads that multiplier's register. The
// per-bar state sits in a RAM with per-entry valid bits, so reset needs no clearing
// pass. The result register frees the core as soon as a result is loaded.
module bar_falloff_smoother (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  bfs_pkg::bfs_item_t           item_data,
    output logic                         result_valid,
    input  logic                         result_stall,
    output bfs_pkg::bfs_result_t         result_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfs_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import bfs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FSQ,
        ST_FDROP,
        ST_FAPPLY,
        ST_IMUL,
        ST_IADD,
        ST_IMEM,
        ST_IFIN,
        ST_SENSE,
        ST_SDOWN,
        ST_RAISE,
        ST_RADD,
        ST_BOOST,
        ST_BADD,
        ST_DONE
    } state_t;

    // configuration registers
    logic [31:0] falloff_coef_reg;
    logic [15:0] integral_coef_reg;
    logic [15:0] full_scale_reg;
    logic        autosense_reg;

    // sequencer and datapath registers
    state_t             state_reg,     state_next;
    logic [30:0]        b_reg,         b_next;
    logic [BAR_AW-1:0]  addr_reg,      addr_next;
    logic               ok_reg,        ok_next;
    logic               fe_reg,        fe_next;
    logic [30:0]        last_reg,      last_next;
    logic [30:0]        peak_reg,      peak_next;
    logic [15:0]        fall_reg,      fall_next;
    logic [30:0]        mem_reg,       mem_next;
    logic [63:0]        prod_reg,      prod_next;
    logic [31:0]        sense_reg,     sense_next;
    logic               low_reg,       low_next;
    logic               first_reg,     first_next;
    logic [BAR_DEPTH-1:0] valid_reg,   valid_next;
    logic               res_valid_reg, res_valid_next;
    bfs_result_t        res_data_reg,  res_data_next;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // RAM interface
    bfs_bar_t          bar_rdata;
    bfs_bar_t          bar_rd;
    bfs_bar_t          bar_wdata;
    logic              ram_we;
    logic              ram_re;
    logic [BAR_AW-1:0] ram_raddr;

    // helpers
    logic        cfg_write;
    logic        out_free;
    state_t      integ_state;
    logic [32:0] drop;
    logic [31:0] isum;
    logic [31:0] imem_y;
    logic [27:0] imem_q;
    logic [32:0] sdown_y;
    logic [32:0] raise_sum;
    logic [32:0] boost_sum;
    logic [30:0] b_clamp;
    logic        overshoot;

    // APB register file: always ready, writes land in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            falloff_coef_reg  <= FALLOFF_COEF_RST;
            integral_coef_reg <= INTEGRAL_COEF_RST;
            full_scale_reg    <= FULL_SCALE_RST;
            autosense_reg     <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (bfs_reg_t'(paddr[3:2]))
                REG_FALLOFF_COEF:  falloff_coef_reg  <= pwdata;
                REG_INTEGRAL_COEF: integral_coef_reg <= pwdata[15:0];
                REG_FULL_SCALE:    full_scale_reg    <= pwdata[15:0];
                REG_AUTOSENSE:     autosense_reg     <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (bfs_reg_t'(paddr[3:2]))
            REG_FALLOFF_COEF:  prdata = falloff_coef_reg;
            REG_INTEGRAL_COEF: prdata = 32'(integral_coef_reg);
            REG_FULL_SCALE:    prdata = 32'(full_scale_reg);
            REG_AUTOSENSE:     prdata = 32'(autosense_reg);
            default:           prdata = '0;
        endcase
    end

    // per-bar state store
    assign ram_re    = item_valid && (state_reg == ST_IDLE);
    assign ram_raddr = BAR_AW'(item_data.bar_index);

    assign bar_wdata.last_level   = last_reg;
    assign bar_wdata.peak_level   = peak_reg;
    assign bar_wdata.fall_count   = fall_reg;
    assign bar_wdata.integral_mem = mem_reg;

    bfs_ram #(
        .WIDTH (BAR_W),
        .DEPTH (BAR_DEPTH)
    ) u_bar_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (bar_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (bar_rdata)
    );

    // entries never written read as cleared; out-of-range bars too
    assign bar_rd = (ok_reg && valid_reg[addr_reg]) ? bar_rdata : '0;

    // handshake
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;
    assign out_free     = !res_valid_reg || !result_stall;

    // multiplier, product registered every cycle
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // post-multiply arithmetic
    assign drop      = 33'(prod_reg[63:32]) + 33'(|prod_reg[31:0]);
    assign isum      = 32'(b_reg) + 32'(prod_reg[46:16]);
    assign imem_y    = 32'(b_reg) + 32'd19;
    assign imem_q    = prod_reg[59:32];
    assign sdown_y   = 33'(sense_reg) + 33'd49;
    assign raise_sum = 33'(sense_reg) + 33'(prod_reg[63:36]);
    assign boost_sum = 33'(sense_reg) + 33'(prod_reg[63:34]);
    assign b_clamp   = (b_reg == 31'd0) ? 31'd1 : b_reg;
    assign overshoot = autosense_reg && (b_clamp > 31'(full_scale_reg)) && low_reg;

    assign integ_state = (integral_coef_reg != 16'd0) ? ST_IMUL : ST_SENSE;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        b_next         = b_reg;
        addr_next      = addr_reg;
        ok_next        = ok_reg;
        fe_next        = fe_reg;
        last_next      = last_reg;
        peak_next      = peak_reg;
        fall_next      = fall_reg;
        mem_next       = mem_reg;
        prod_next      = mul_p;
        sense_next     = sense_reg;
        low_next       = low_reg;
        first_next     = first_reg;
        valid_next     = valid_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_data_next  = res_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    b_next     = item_data.raw_level;
                    fe_next    = item_data.frame_end;
                    addr_next  = BAR_AW'(item_data.bar_index);
                    ok_next    = (32'(item_data.bar_index) < NUM_BARS);
                    state_next = ST_LOAD;
                end
            end

            // take the bar state; with falloff on, a level at or above the last one takes the peak
            ST_LOAD:
            begin
                last_next = bar_rd.last_level;
                peak_next = bar_rd.peak_level;
                fall_next = bar_rd.fall_count;
                mem_next  = bar_rd.integral_mem;
                if (falloff_coef_reg == 32'd0)
                begin
                    state_next = integ_state;
                end
                else if (b_reg < bar_rd.last_level)
                begin
                    state_next = ST_FSQ;
                end
                else
                begin
                    peak_next  = b_reg;
                    fall_next  = 16'd0;
                    last_next  = b_reg;
                    state_next = integ_state;
                end
            end

            // fall squared
            ST_FSQ:
            begin
                mul_a      = 32'(fall_reg);
                mul_b      = 32'(fall_reg);
                state_next = ST_FDROP;
            end

            // coefficient times fall squared
            ST_FDROP:
            begin
                mul_a      = falloff_coef_reg;
                mul_b      = prod_reg[31:0];
                state_next = ST_FAPPLY;
            end

            // peak minus rounded-up drop, floor at zero
            ST_FAPPLY:
            begin
                if (drop >= 33'(peak_reg))
                begin
                    b_next    = '0;
                    last_next = '0;
                end
                else
                begin
                    b_next    = peak_reg - drop[30:0];
                    last_next = peak_reg - drop[30:0];
                end
                if (fall_reg != 16'hFFFF)
                begin
                    fall_next = fall_reg + 16'd1;
                end
                state_next = integ_state;
            end

            // memory share
            ST_IMUL:
            begin
                mul_a      = 32'(mem_reg);
                mul_b      = 32'(integral_coef_reg);
                state_next = ST_IADD;
            end

            ST_IADD:
            begin
                b_next     = isum[31] ? 31'h7FFF_FFFF : isum[30:0];
                state_next = ST_IMEM;
            end

            // ceil(b/20) = floor(((b + 19) >> 2) / 5)
            ST_IMEM:
            begin
                mul_a      = 32'(imem_y[31:2]);
                mul_b      = RECIP_5_Q32;
                state_next = ST_IFIN;
            end

            // memory decays to 19/20 of b at full scale
            ST_IFIN:
            begin
                if (b_reg >= 31'(full_scale_reg))
                begin
                    mem_next = b_reg - 31'(imem_q);
                end
                else
                begin
                    mem_next = b_reg;
                end
                state_next = ST_SENSE;
            end

            // clamp, overshoot check; the 49/50 product is started speculatively
            ST_SENSE:
            begin
                mul_a  = sdown_y[32:1];
                mul_b  = RECIP_25_Q36;
                b_next = b_clamp;
                if (overshoot)
                begin
                    low_next   = 1'b0;
                    first_next = 1'b0;
                    state_next = ST_SDOWN;
                end
                else if (fe_reg && autosense_reg && low_reg)
                begin
                    state_next = ST_RAISE;
                end
                else
                begin
                    if (fe_reg)
                    begin
                        low_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end

            // sense - ceil(sense/50); the frame-end raise is skipped after a drop
            ST_SDOWN:
            begin
                sense_next = sense_reg - 32'(prod_reg[63:36]);
                if (fe_reg)
                begin
                    low_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            // sense / 1000
            ST_RAISE:
            begin
                mul_a      = 32'(sense_reg[31:3]);
                mul_b      = RECIP_125_Q36;
                state_next = ST_RADD;
            end

            ST_RADD:
            begin
                sense_next = raise_sum[32] ? 32'hFFFF_FFFF : raise_sum[31:0];
                state_next = first_reg ? ST_BOOST : ST_DONE;
            end

            // sense / 10, until the first overshoot ever
            ST_BOOST:
            begin
                mul_a      = 32'(sense_reg[31:1]);
                mul_b      = RECIP_5_Q34;
                state_next = ST_BADD;
            end

            ST_BADD:
            begin
                sense_next = boost_sum[32] ? 32'hFFFF_FFFF : boost_sum[31:0];
                state_next = ST_DONE;
            end

            // write back and hand off once the result register is free
            ST_DONE:
            begin
                if (out_free)
                begin
                    ram_we = ok_reg;
                    if (ok_reg)
                    begin
                        valid_next[addr_reg] = 1'b1;
                    end
                    res_valid_next            = 1'b1;
                    res_data_next.brightness  = b_reg;
                    res_data_next.sensitivity = sense_reg;
                    res_data_next.frame_done  = fe_reg;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            b_reg         <= '0;
            addr_reg      <= '0;
            ok_reg        <= 1'b0;
            fe_reg        <= 1'b0;
            last_reg      <= '0;
            peak_reg      <= '0;
            fall_reg      <= '0;
            mem_reg       <= '0;
            prod_reg      <= '0;
            sense_reg     <= SENSE_RST;
            low_reg       <= 1'b1;
            first_reg     <= 1'b1;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            b_reg         <= b_next;
            addr_reg      <= addr_next;
            ok_reg        <= ok_next;
            fe_reg        <= fe_next;
            last_reg      <= last_next;
            peak_reg      <= peak_next;
            fall_reg      <= fall_next;
            mem_reg       <= mem_next;
            prod_reg      <= prod_next;
            sense_reg     <= sense_next;
            low_reg       <= low_next;
            first_reg     <= first_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a new result only comes from the write-back step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> (state_reg == ST_IDLE) && ($past(state_reg) == ST_DONE))
        else $error("result raised outside write-back");

    // sensitivity only moves while a request is in work
    a_sense_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(sense_reg))
        else $error("sensitivity changed while idle");

    // brightness is clamped to at least one
    a_brightness_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.brightness != 31'd0))
        else $error("zero brightness delivered");

    // a frame end always rearms the lowering
    a_frame_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(result_valid) && result_data.frame_done) |-> low_reg)
        else $error("lowering not rearmed at frame end");
`endif

endmodule

// ===== rtl/bfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench for the bar falloff smoother: random-stalled request streams checked against a local predictor.
`timescale 1ns / 1ps

module testbench;
    import bfs_pkg::*;

    localparam logic [30:0] LEVEL_MAX = 31'h7FFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    bfs_item_t   item_data = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    bfs_result_t result_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bar_falloff_smoother uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Predictor copy of the registers
    logic [31:0] cfg_falloff   = FALLOFF_COEF_RST;
    logic [15:0] cfg_integral  = INTEGRAL_COEF_RST;
    logic [15:0] cfg_full      = FULL_SCALE_RST;
    logic        cfg_autosense = 1'b1;

    // Predictor copy of the per-bar and autosense state
    logic [30:0] shown_level [NUM_BARS];
    logic [30:0] held_peak   [NUM_BARS];
    logic [15:0] fall_steps  [NUM_BARS];
    logic [30:0] smooth_mem  [NUM_BARS];
    logic [31:0] sense       = SENSE_RST;
    logic        sense_armed = 1'b1;
    logic        first_frame = 1'b1;

    // Generator memory of the raw level last sent per bar
    int unsigned src_level [NUM_BARS];

    bfs_item_t   raw_bar_q[$];
    bfs_result_t smoothed_q[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    bfs_result_t want;

    function automatic logic [31:0] scale_sense(logic [31:0] v, int unsigned num,
                                                int unsigned den);
        longint unsigned r;
        r = (64'(v) * 64'(num)) / 64'(den);
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    // Falloff, smoothing and autosense for one bar request; updates predictor state
    function automatic bfs_result_t smooth_bar(bfs_item_t req);
        bfs_result_t     res;
        longint unsigned lvl;
        longint unsigned last;
        longint unsigned peak;
        longint unsigned fall;
        longint unsigned mem;
        longint unsigned drop;
        longint unsigned sum;
        int unsigned     idx;
        idx  = 32'(req.bar_index);
        lvl  = 64'(req.raw_level);
        last = 64'(shown_level[idx]);
        peak = 64'(held_peak[idx]);
        fall = 64'(fall_steps[idx]);
        mem  = 64'(smooth_mem[idx]);

        // gravity falloff: drop = ceil(coef * fall^2 / 2^32)
        if (cfg_falloff != 0)
        begin
            if (lvl < last)
            begin
                drop = (64'(cfg_falloff) * (fall * fall) + 64'hFFFF_FFFF) >> 32;
                lvl = (drop >= peak) ? 64'd0 : peak - drop;
                if (fall < 64'hFFFF)
                    fall++;
            end
            else
            begin
                peak = lvl;
                fall = 0;
            end
            last = lvl;
        end

        // integral smoothing, memory scaled by 19/20 at full scale
        if (cfg_integral != 0)
        begin
            sum = lvl + ((mem * 64'(cfg_integral)) >> 16);
            lvl = (sum > 64'(LEVEL_MAX)) ? 64'(LEVEL_MAX) : sum;
            mem = (lvl >= 64'(cfg_full)) ? (lvl * 64'd19) / 64'd20 : lvl;
        end

        if (lvl == 0)
            lvl = 1;

        // autosense: one drop per frame, raise at frame end
        if (cfg_autosense && lvl > 64'(cfg_full) && sense_armed)
        begin
            sense = scale_sense(sense, 49, 50);
            sense_armed = 1'b0;
            first_frame = 1'b0;
        end
        if (req.frame_end)
        begin
            if (cfg_autosense && sense_armed)
            begin
                sense = scale_sense(sense, 1001, 1000);
                if (first_frame)
                    sense = scale_sense(sense, 11, 10);
            end
            sense_armed = 1'b1;
        end

        shown_level[idx] = last[30:0];
        held_peak[idx]   = peak[30:0];
        fall_steps[idx]  = fall[15:0];
        smooth_mem[idx]  = mem[30:0];

        res.brightness  = lvl[30:0];
        res.sensitivity = sense;
        res.frame_done  = req.frame_end;
        return res;
    endfunction

    // Request driver: predicts on acceptance, then loads the next pending request
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
                smoothed_q.push_back(smooth_bar(item_data));
            if (raw_bar_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item_data  <= raw_bar_q.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver stall
    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (smoothed_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: b=%0d s=%0h fd=%0b", $realtime,
                             result_data.brightness, result_data.sensitivity,
                             result_data.frame_done);
            end
            else
            begin
                want = smoothed_q.pop_front();
                if (want.brightness !== result_data.brightness
                    || want.sensitivity !== result_data.sensitivity
                    || want.frame_done !== result_data.frame_done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: expected b=%0d s=%0h fd=%0b, got b=%0d s=%0h fd=%0b",
                                 $realtime, want.brightness, want.sensitivity, want.frame_done,
                                 result_data.brightness, result_data.sensitivity,
                                 result_data.frame_done);
                end
            end
        end
    end

    task automatic queue_bar(int unsigned idx, logic [30:0] lvl, logic fe);
        bfs_item_t req;
        req.bar_index = idx[7:0];
        req.raw_level = lvl;
        req.frame_end = fe;
        raw_bar_q.push_back(req);
    endtask

    // Wait until every request is accepted and answered, then let the core settle;
    // the check runs after the edge has settled so a request loaded at that edge counts
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (raw_bar_q.size() != 0 || item_valid || smoothed_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(bfs_reg_t r, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_FALLOFF_COEF:  cfg_falloff   = v;
            REG_INTEGRAL_COEF: cfg_integral  = v[15:0];
            REG_FULL_SCALE:    cfg_full      = v[15:0];
            REG_AUTOSENSE:     cfg_autosense = v[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [31:0] falloff, logic [15:0] integral,
                                logic [15:0] full, logic autosense);
        write_reg(REG_FALLOFF_COEF, falloff);
        write_reg(REG_INTEGRAL_COEF, {16'd0, integral});
        write_reg(REG_FULL_SCALE, {16'd0, full});
        write_reg(REG_AUTOSENSE, {31'd0, autosense});
    endtask

    // Next raw level for a bar: mostly decays and small steps, some extremes
    function automatic logic [30:0] next_level(int unsigned idx);
        longint unsigned prev;
        longint unsigned v;
        prev = 64'(src_level[idx]);
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 64'(LEVEL_MAX);
            2: v = 64'($urandom & 32'(LEVEL_MAX));
            3, 4, 5: v = (prev == 0) ? 64'd0
                         : prev - 64'd1 - 64'($urandom_range(0, 32'(prev / 8)));
            6: v = 64'($urandom_range(0, 2 * cfg_full + 2));
            7: v = 64'($urandom_range(0, 255));
            8: v = prev + 64'($urandom_range(0, 1000));
            default: v = prev;
        endcase
        if (v > 64'(LEVEL_MAX))
            v = 64'(LEVEL_MAX);
        src_level[idx] = 32'(v);
        return v[30:0];
    endfunction

    // Frames of consecutive bars from one base, with some stray requests mixed in
    task automatic queue_frames(int unsigned count);
        int unsigned base;
        int unsigned len;
        int unsigned idx;
        int unsigned sent;
        bit          stray;
        base = $urandom_range(0, 255);
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 12);
            for (int unsigned i = 0; i < len; i++)
            begin
                stray = ($urandom_range(0, 9) == 0);
                idx = stray ? $urandom_range(0, 255) : (base + i) % NUM_BARS;
                queue_bar(idx, next_level(idx),
                          stray ? 1'($urandom_range(0, 1)) : (i == len - 1));
            end
            sent += len;
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_BARS; i++)
        begin
            shown_level[i] = '0;
            held_peak[i]   = '0;
            fall_steps[i]  = '0;
            smooth_mem[i]  = '0;
            src_level[i]   = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 32;
        recv_stall_pct = 84;

        // Startup ramp: one-bar frames below full scale drive the strong raise
        // until the sensitivity saturates
        for (int i = 0; i < 80; i++)
            queue_bar($urandom_range(0, 255), 31'($urandom_range(0, 20000)), 1'b1);

        // Directed: extremes, falling bar, overshoot, one drop per frame, rearming
        queue_bar(0, LEVEL_MAX, 1'b0);
        queue_bar(0, 31'd0, 1'b0);
        queue_bar(0, 31'd0, 1'b0);
        queue_bar(0, 31'd0, 1'b1);
        queue_bar(255, LEVEL_MAX, 1'b0);
        queue_bar(255, 31'h2AAA_AAAA, 1'b0);
        queue_bar(1, 31'h5555_5555, 1'b1);
        queue_bar(2, 31'd0, 1'b1);
        queue_bar(3, 31'd65534, 1'b0);
        queue_bar(4, 31'd65535, 1'b1);
        queue_bar(32'hAA, 31'd1, 1'b0);
        queue_bar(32'h55, 31'd2, 1'b1);
        queue_bar(0, 31'd1, 1'b0);
        queue_bar(0, 31'd0, 1'b1);
        wait_idle();

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct  = (p < 2) ? 32 : (p < 4) ? 84 : 0;
            recv_stall_pct = (p < 2) ? 84 : (p < 4) ? 32 : 0;
            case (p)
                0: program_regs(FALLOFF_COEF_RST, INTEGRAL_COEF_RST, FULL_SCALE_RST, 1'b1);
                1: program_regs(32'd0, 16'd0, 16'd0, 1'b0);
                2: program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                3: program_regs($urandom, 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                4: program_regs($urandom_range(1 << 20, 1 << 28),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 5000)), 1'b1);
                default: program_regs(32'hFFFF_FFFF, 16'd0, 16'd0, 1'b1);
            endcase
            queue_frames(170);
            wait_idle();
        end

        // Long fall on one bar with the smallest coefficient
        program_regs(32'd1, 16'd0, FULL_SCALE_RST, 1'b0);
        queue_bar(7, LEVEL_MAX, 1'b0);
        for (int i = 0; i < 60; i++)
            queue_bar(7, 31'($urandom & 32'h3FFF_FFFF), (i % 16) == 15);
        wait_idle();

        if (mismatch_count == 0)
            $display("bar_falloff_smoother verification clean");
        else
            $display("bar_falloff_smoother verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #100ms;
        $display("bar_falloff_smoother verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bfs_pkg.sv
rtl/bfs_ram.sv
rtl/bar_falloff_smoother.sv
sim/testbench.sv
